>>> rtl/wswm_pkg.sv
// Shared types, constants and date arithmetic for the weekly schedule window matcher.
package wswm_pkg;

  localparam int unsigned ActSlotsDefault = 16;
  localparam int unsigned ExcSlotsDefault = 8;
  localparam logic [31:0] SecsPerDay      = 32'd86400;

  localparam logic [1:0] MODE_QUERY   = 2'd0;
  localparam logic [1:0] MODE_ADD_ACT = 2'd1;
  localparam logic [1:0] MODE_ADD_EXC = 2'd2;

  localparam logic [1:0] CFG_ACT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_EXC_LIMIT = 2'd1;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  weekday;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [16:0] secs1;
    logic [16:0] start;
    logic [16:0] dur;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic active;
    logic accepted;
    logic available;
  } res_t;

  // One stored activity.
  typedef struct packed {
    logic [31:0] pbegin;
    logic [31:0] pend;
    logic [2:0]  weekday;
    logic [16:0] start;
    logic [16:0] dur;
  } act_t;

  // Days in the year before the first of each month, for a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    begin
      case (m)
        4'd1:    r = 9'd0;
        4'd2:    r = 9'd31;
        4'd3:    r = 9'd59;
        4'd4:    r = 9'd90;
        4'd5:    r = 9'd120;
        4'd6:    r = 9'd151;
        4'd7:    r = 9'd181;
        4'd8:    r = 9'd212;
        4'd9:    r = 9'd243;
        4'd10:   r = 9'd273;
        4'd11:   r = 9'd304;
        default: r = 9'd334;
      endcase
      return r;
    end
  endfunction

  // Day number on the timeline; the day before 2000-01-01 is day zero.
  function automatic logic [15:0] day_number(input logic [6:0] y, input logic [3:0] mo,
                                             input logic [4:0] d);
    logic [3:0]  m;
    logic [15:0] n;
    begin
      m = mo;
      if (m == 4'd0) m = 4'd1;
      if (m > 4'd12) m = 4'd12;
      n = 16'(16'(y) * 16'd365) + 16'((8'(y) + 8'd3) >> 2) + 16'(days_before(m))
          + 16'(d);
      if (y[1:0] == 2'b00 && m > 4'd2) n = n + 16'd1;
      return n;
    end
  endfunction

endpackage

>>> rtl/wswm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wswm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wswm_fifo.sv
// Small first-in first-out queue with a combinational head.
module wswm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(cnt_q) <= DEPTH)
    else $error("fifo count above depth");
  // A push without a pop on a non-full queue grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("fifo count did not grow");
  // The queue is never full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(full_o && empty_o))
    else $error("fifo full and empty together");

endmodule

>>> rtl/wswm_front.sv
// Front part: takes input transactions, converts dates to timeline seconds, classifies.
module wswm_front
  import wswm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  weekday_i,
  input  logic [6:0]  first_year_i,
  input  logic [3:0]  first_month_i,
  input  logic [4:0]  first_day_i,
  input  logic [16:0] first_secs_i,
  input  logic [6:0]  second_year_i,
  input  logic [3:0]  second_month_i,
  input  logic [4:0]  second_day_i,
  input  logic [16:0] second_secs_i,
  input  logic [16:0] start_secs_i,
  input  logic [16:0] duration_secs_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  logic        vld_q, vld_d;
  logic [1:0]  mode_q;
  logic [2:0]  wd_q;
  logic [15:0] dn1_q, dn2_q;
  logic [16:0] secs1_q, secs2_q, start_q, dur_q;
  logic [16:0] dur_red;
  logic        accept;

  assign full_o     = vld_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = vld_q && !cmd_full_i;

  // Duration reduced modulo one day: it is always below two days.
  assign dur_red = (duration_secs_i >= 17'(SecsPerDay)) ?
                   duration_secs_i - 17'(SecsPerDay) : duration_secs_i;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (cmd_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // First stage: day numbers of both dates.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      wd_q    <= weekday_i;
      dn1_q   <= day_number(first_year_i, first_month_i, first_day_i);
      dn2_q   <= day_number(second_year_i, second_month_i, second_day_i);
      secs1_q <= first_secs_i;
      secs2_q <= second_secs_i;
      start_q <= start_secs_i;
      dur_q   <= dur_red;
    end
  end

  // Second stage: scale to seconds and add the time of day.
  always_comb begin
    cmd_o.mode    = mode_q;
    cmd_o.weekday = wd_q;
    cmd_o.t1      = 32'(32'(dn1_q) * SecsPerDay) + 32'(secs1_q);
    cmd_o.t2      = 32'(32'(dn2_q) * SecsPerDay) + 32'(secs2_q);
    cmd_o.secs1   = secs1_q;
    cmd_o.start   = start_q;
    cmd_o.dur     = dur_q;
  end

  // Input is refused only while a converted item waits on a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> (vld_q && cmd_full_i))
    else $error("front stalls without cause");
  // A held item that cannot move stays held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (vld_q && cmd_full_i) |=> vld_q)
    else $error("front lost an item");
  // A fresh item becomes valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> vld_q)
    else $error("front dropped an accepted item");

endmodule

>>> rtl/wswm_back.sv
// Back part: stores adds and scans the exception and activity tables for queries.
module wswm_back
  import wswm_pkg::*;
#(
  parameter int unsigned ACT_SLOTS = ActSlotsDefault,
  parameter int unsigned EXC_SLOTS = ExcSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  logic       res_full_i,
  output logic       res_push_o,
  output res_t       res_o
);

  localparam int unsigned AAW = (ACT_SLOTS > 1) ? $clog2(ACT_SLOTS) : 1;
  localparam int unsigned EAW = (EXC_SLOTS > 1) ? $clog2(EXC_SLOTS) : 1;
  localparam int unsigned ACW = $clog2(ACT_SLOTS + 1);
  localparam int unsigned ECW = $clog2(EXC_SLOTS + 1);
  localparam int unsigned IW  = (ACW > ECW) ? ACW : ECW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXC  = 2'd1;
  localparam logic [1:0] ST_ACT  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]     st_q, st_d;
  cmd_t           cur_q, cur_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           chk_q, chk_d;
  logic           inexc_q, inexc_d, hit_q, hit_d;
  logic [ACW-1:0] act_cnt_q, act_cnt_d;
  logic [ECW-1:0] exc_cnt_q, exc_cnt_d;
  logic           active_q, active_d, avail_q, avail_d;
  logic [4:0]     act_lim_q;
  logic [3:0]     exc_lim_q;
  logic           act_we, exc_we;
  act_t           act_wdata, act_rdata;
  logic [63:0]    exc_rdata;
  logic [31:0]    eb, ee;
  logic           act_room, exc_room;

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_lim_q <= 5'd16;
      exc_lim_q <= 4'd8;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ACT_LIMIT) act_lim_q <= cfg_data_i;
      if (cfg_index_i == CFG_EXC_LIMIT) exc_lim_q <= cfg_data_i[3:0];
    end
  end

  assign act_room = (32'(act_cnt_q) < 32'(act_lim_q)) && (32'(act_cnt_q) < ACT_SLOTS);
  assign exc_room = (32'(exc_cnt_q) < 32'(exc_lim_q)) && (32'(exc_cnt_q) < EXC_SLOTS);

  assign act_wdata = '{pbegin: cmd_i.t1, pend: cmd_i.t2, weekday: cmd_i.weekday,
                       start: cmd_i.start, dur: cmd_i.dur};
  assign eb = exc_rdata[63:32];
  assign ee = exc_rdata[31:0];

  wswm_ram #(.WIDTH($bits(act_t)), .DEPTH(ACT_SLOTS)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_cnt_q[AAW-1:0]),
    .wdata_i (act_wdata),
    .raddr_i (idx_q[AAW-1:0]),
    .rdata_o (act_rdata)
  );

  wswm_ram #(.WIDTH(64), .DEPTH(EXC_SLOTS)) u_exc_ram (
    .clk_i   (clk_i),
    .we_i    (exc_we),
    .waddr_i (exc_cnt_q[EAW-1:0]),
    .wdata_i ({cmd_i.t1, cmd_i.t2}),
    .raddr_i (idx_q[EAW-1:0]),
    .rdata_o (exc_rdata)
  );

  // Sequencer: one table entry per cycle, read data in the cycle after its address.
  always_comb begin
    st_d      = st_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    chk_d     = 1'b0;
    inexc_d   = inexc_q;
    hit_d     = hit_q;
    act_cnt_d = act_cnt_q;
    exc_cnt_d = exc_cnt_q;
    active_d  = active_q;
    avail_d   = avail_q;
    act_we    = 1'b0;
    exc_we    = 1'b0;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o     = '{active: active_q, accepted: 1'b0, available: avail_q};
    case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          idx_d     = '0;
          inexc_d   = 1'b0;
          hit_d     = 1'b0;
          case (cmd_i.mode)
            MODE_QUERY: begin
              st_d = ST_EXC;
            end
            MODE_ADD_ACT: begin
              res_push_o = 1'b1;
              if (act_room) begin
                act_we         = 1'b1;
                act_cnt_d      = act_cnt_q + ACW'(1);
                avail_d        = 1'b1;
                res_o.accepted = 1'b1;
                res_o.available = 1'b1;
              end
            end
            MODE_ADD_EXC: begin
              res_push_o = 1'b1;
              if (exc_room) begin
                exc_we         = 1'b1;
                exc_cnt_d      = exc_cnt_q + ECW'(1);
                res_o.accepted = 1'b1;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_EXC: begin
        if (chk_q && cur_q.t1 > eb && ee > cur_q.t1) begin
          inexc_d = 1'b1;
        end
        if (32'(idx_q) < 32'(exc_cnt_q)) begin
          idx_d = idx_q + IW'(1);
          chk_d = 1'b1;
        end else if (!chk_q) begin
          idx_d = '0;
          st_d  = (inexc_q || cur_q.weekday == 3'd0) ? ST_DONE : ST_ACT;
        end
      end
      ST_ACT: begin
        if (chk_q && act_rdata.weekday == cur_q.weekday &&
            cur_q.t1 > act_rdata.pbegin && act_rdata.pend > cur_q.t1 &&
            act_rdata.start < cur_q.secs1 &&
            (18'(act_rdata.start) + 18'(act_rdata.dur)) > 18'(cur_q.secs1)) begin
          hit_d = 1'b1;
        end
        if (32'(idx_q) < 32'(act_cnt_q)) begin
          idx_d = idx_q + IW'(1);
          chk_d = 1'b1;
        end else if (!chk_q) begin
          st_d = ST_DONE;
        end
      end
      default: begin
        res_push_o   = 1'b1;
        active_d     = hit_q;
        res_o.active = hit_q;
        st_d         = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      idx_q     <= '0;
      chk_q     <= 1'b0;
      inexc_q   <= 1'b0;
      hit_q     <= 1'b0;
      act_cnt_q <= '0;
      exc_cnt_q <= '0;
      active_q  <= 1'b0;
      avail_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      chk_q     <= chk_d;
      inexc_q   <= inexc_d;
      hit_q     <= hit_d;
      act_cnt_q <= act_cnt_d;
      exc_cnt_q <= exc_cnt_d;
      active_q  <= active_d;
      avail_q   <= avail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Table counts stay within the slot counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   32'(act_cnt_q) <= ACT_SLOTS && 32'(exc_cnt_q) <= EXC_SLOTS)
    else $error("table count above slot count");
  // A result is pushed only into a queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");
  // The available flag never falls once set.
  assert property (@(posedge clk_i) disable iff (!rst_ni) avail_q |=> avail_q)
    else $error("available flag cleared");
  // A stored activity always raises the available flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni) act_we |=> avail_q)
    else $error("activity stored without available flag");

endmodule

>>> rtl/weekly_schedule_window_matcher.sv
// Top level of the weekly schedule window matcher.
// Path: an input is registered in the front part, converted and written into the command
// queue, then taken by the back part and written into the result queue. A query result
// also waits on the scan of the exception table and, where needed, the activity table,
// since the back part reads one RAM entry per cycle. The back part takes one item at a time.
// Reset (rst_ni low, asynchronous) empties both tables and queues, clears the flags
// and sets the limits to 16 and 8; no clearing pass is needed.
module weekly_schedule_window_matcher
  import wswm_pkg::*;
#(
  parameter int unsigned ACT_SLOTS = ActSlotsDefault,
  parameter int unsigned EXC_SLOTS = ExcSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  weekday_i,
  input  logic [6:0]  first_year_i,
  input  logic [3:0]  first_month_i,
  input  logic [4:0]  first_day_i,
  input  logic [16:0] first_secs_i,
  input  logic [6:0]  second_year_i,
  input  logic [3:0]  second_month_i,
  input  logic [4:0]  second_day_i,
  input  logic [16:0] second_secs_i,
  input  logic [16:0] start_secs_i,
  input  logic [16:0] duration_secs_i,
  output logic        empty,
  input  logic        pop,
  output logic        active_o,
  output logic        accepted_o,
  output logic        available_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  logic res_push, res_full;
  res_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  wswm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .mode_i          (mode_i),
    .weekday_i       (weekday_i),
    .first_year_i    (first_year_i),
    .first_month_i   (first_month_i),
    .first_day_i     (first_day_i),
    .first_secs_i    (first_secs_i),
    .second_year_i   (second_year_i),
    .second_month_i  (second_month_i),
    .second_day_i    (second_day_i),
    .second_secs_i   (second_secs_i),
    .start_secs_i    (start_secs_i),
    .duration_secs_i (duration_secs_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in),
    .cmd_full_i      (cmd_full)
  );

  // Command queue between the front and the back.
  wswm_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  wswm_back #(.ACT_SLOTS(ACT_SLOTS), .EXC_SLOTS(EXC_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue toward the consumer.
  wswm_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign active_o    = res_out.active;
  assign accepted_o  = res_out.accepted;
  assign available_o = res_out.available;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the weekly schedule window matcher.
module tb_top
  import wswm_pkg::*;
();

  localparam int unsigned ActSlots    = 16;
  localparam int unsigned ExcSlots    = 8;
  localparam int unsigned DaySecs     = 86400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [1:0]  MODE_NOP    = 2'd3;

  typedef struct {
    bit [1:0]  mode;
    bit [2:0]  weekday;
    bit [6:0]  y1;
    bit [3:0]  m1;
    bit [4:0]  d1;
    bit [16:0] s1;
    bit [6:0]  y2;
    bit [3:0]  m2;
    bit [4:0]  d2;
    bit [16:0] s2;
    bit [16:0] start;
    bit [16:0] dur;
  } sched_item_t;

  typedef struct {
    bit active;
    bit accepted;
    bit available;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode_i = '0;
  logic [2:0]  weekday_i = '0;
  logic [6:0]  first_year_i = '0;
  logic [3:0]  first_month_i = 4'd1;
  logic [4:0]  first_day_i = 5'd1;
  logic [16:0] first_secs_i = '0;
  logic [6:0]  second_year_i = '0;
  logic [3:0]  second_month_i = 4'd1;
  logic [4:0]  second_day_i = 5'd1;
  logic [16:0] second_secs_i = '0;
  logic [16:0] start_secs_i = '0;
  logic [16:0] duration_secs_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        active_o;
  logic        accepted_o;
  logic        available_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  // Scoreboard state: a private copy of the schedule tables and limits.
  bit [31:0] sch_act_begin[ActSlots];
  bit [31:0] sch_act_end[ActSlots];
  bit [2:0]  sch_act_wd[ActSlots];
  bit [16:0] sch_act_start[ActSlots];
  bit [16:0] sch_act_dur[ActSlots];
  sched_item_t sch_act_src[ActSlots];
  int unsigned sch_act_cnt;
  bit [31:0] sch_exc_begin[ExcSlots];
  bit [31:0] sch_exc_end[ExcSlots];
  int unsigned sch_exc_cnt;
  bit        sch_active;
  bit        sch_available;
  bit [4:0]  lim_act;
  bit [3:0]  lim_exc;

  verdict_t  pending_verdicts[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned idle_cycles;
  bit          push_up;
  bit          send_calm;
  bit          pop_calm;
  bit          hold_req;
  bit          hold_on;

  weekly_schedule_window_matcher i_dut (
    .clk_i, .rst_ni, .push, .full, .mode_i, .weekday_i,
    .first_year_i, .first_month_i, .first_day_i, .first_secs_i,
    .second_year_i, .second_month_i, .second_day_i, .second_secs_i,
    .start_secs_i, .duration_secs_i, .empty, .pop,
    .active_o, .accepted_o, .available_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Days elapsed since 1999-12-31, with out-of-range months clamped.
  function automatic int unsigned calendar_day(bit [6:0] y, bit [3:0] m, bit [4:0] d);
    int unsigned cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned mm;
    int unsigned n;
    mm = (m == 0) ? 1 : ((m > 12) ? 12 : m);
    n = 365 * y + (y + 3) / 4 + cum[mm - 1] + d;
    if (y % 4 == 0 && mm > 2) n++;
    return n;
  endfunction

  function automatic bit [31:0] abs_secs(bit [6:0] y, bit [3:0] m, bit [4:0] d,
                                         bit [16:0] s);
    return 32'(calendar_day(y, m, d) * DaySecs + s);
  endfunction

  // Applies one transaction to the schedule copy and returns its verdict.
  function automatic verdict_t schedule_verdict(sched_item_t it);
    verdict_t v;
    bit [31:0] t1;
    bit [31:0] t2;
    longint unsigned base;
    longint unsigned ws;
    bit blocked;
    bit hit;
    t1 = abs_secs(it.y1, it.m1, it.d1, it.s1);
    t2 = abs_secs(it.y2, it.m2, it.d2, it.s2);
    v.accepted = 1'b0;
    case (it.mode)
      MODE_QUERY: begin
        blocked = 1'b0;
        hit = 1'b0;
        base = longint'(calendar_day(it.y1, it.m1, it.d1)) * DaySecs;
        for (int i = 0; i < sch_exc_cnt; i++)
          if (t1 > sch_exc_begin[i] && sch_exc_end[i] > t1) blocked = 1'b1;
        if (!blocked && it.weekday != 0) begin
          for (int i = 0; i < sch_act_cnt; i++) begin
            ws = base + sch_act_start[i];
            if (sch_act_wd[i] == it.weekday && t1 > sch_act_begin[i] &&
                sch_act_end[i] > t1 && t1 > ws && ws + sch_act_dur[i] > t1)
              hit = 1'b1;
          end
        end
        sch_active = hit;
      end
      MODE_ADD_ACT: begin
        if (sch_act_cnt < lim_act && sch_act_cnt < ActSlots) begin
          sch_act_begin[sch_act_cnt] = t1;
          sch_act_end[sch_act_cnt]   = t2;
          sch_act_wd[sch_act_cnt]    = it.weekday;
          sch_act_start[sch_act_cnt] = it.start;
          sch_act_dur[sch_act_cnt]   = 17'(it.dur % DaySecs);
          sch_act_src[sch_act_cnt]   = it;
          sch_act_cnt++;
          sch_available = 1'b1;
          v.accepted = 1'b1;
        end
      end
      MODE_ADD_EXC: begin
        if (sch_exc_cnt < lim_exc && sch_exc_cnt < ExcSlots) begin
          sch_exc_begin[sch_exc_cnt] = t1;
          sch_exc_end[sch_exc_cnt]   = t2;
          sch_exc_cnt++;
          v.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    v.active = sch_active;
    v.available = sch_available;
    return v;
  endfunction

  // Lowers push if it was left up after the last accepted transaction.
  task automatic release_push();
    if (push_up) begin
      push <= 1'b0;
      push_up = 1'b0;
    end
  endtask

  // Offers one item, waits for acceptance, records its expected verdict.
  task automatic send_item(sched_item_t it);
    push            <= 1'b1;
    push_up          = 1'b1;
    mode_i          <= it.mode;
    weekday_i       <= it.weekday;
    first_year_i    <= it.y1;
    first_month_i   <= it.m1;
    first_day_i     <= it.d1;
    first_secs_i    <= it.s1;
    second_year_i   <= it.y2;
    second_month_i  <= it.m2;
    second_day_i    <= it.d2;
    second_secs_i   <= it.s2;
    start_secs_i    <= it.start;
    duration_secs_i <= it.dur;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_verdicts.insert(pending_verdicts.size(), schedule_verdict(it));
    items_sent++;
    if (!send_calm && $urandom_range(99) < 36) begin
      release_push();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Pauses the sender until every expected result has come back.
  task automatic drain();
    release_push();
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [4:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ACT_LIMIT) lim_act = val;
    else if (idx == CFG_EXC_LIMIT) lim_exc = val[3:0];
  endtask

  function automatic sched_item_t mk_item(bit [1:0] mode, bit [2:0] wd,
      bit [6:0] y1, bit [3:0] m1, bit [4:0] d1, bit [16:0] s1,
      bit [6:0] y2, bit [3:0] m2, bit [4:0] d2, bit [16:0] s2,
      bit [16:0] start, bit [16:0] dur);
    sched_item_t it;
    it = '{mode, wd, y1, m1, d1, s1, y2, m2, d2, s2, start, dur};
    return it;
  endfunction

  // Any bit pattern at all, the unused mode included.
  function automatic sched_item_t noise_item();
    return mk_item(2'($urandom), 3'($urandom), 7'($urandom), 4'($urandom), 5'($urandom),
                   17'($urandom), 7'($urandom), 4'($urandom), 5'($urandom), 17'($urandom),
                   17'($urandom), 17'($urandom));
  endfunction

  // A sensible activity with a multi-year period.
  function automatic sched_item_t activity_item();
    int unsigned yb;
    yb = $urandom_range(0, 60);
    return mk_item(MODE_ADD_ACT, 3'($urandom_range(1, 7)), 7'(yb), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 28)), 17'($urandom_range(0, 86399)),
                   7'(yb + $urandom_range(2, 39)), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 28)), 17'($urandom_range(0, 86399)),
                   17'($urandom_range(0, 80000)), 17'($urandom_range(60, 40000)));
  endfunction

  // A short exception period somewhere in the century.
  function automatic sched_item_t exception_item();
    int unsigned yb;
    yb = $urandom_range(0, 99);
    return mk_item(MODE_ADD_EXC, 3'($urandom), 7'(yb), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 28)), 17'($urandom_range(0, 86399)),
                   7'(yb), 4'($urandom_range(1, 12)), 5'($urandom_range(1, 28)),
                   17'($urandom_range(0, 86399)), 17'($urandom), 17'($urandom));
  endfunction

  // A query aimed at a stored activity, near or inside its daily window.
  function automatic sched_item_t aimed_query();
    sched_item_t a;
    int unsigned s;
    if (sch_act_cnt == 0) return noise_item();
    a = sch_act_src[$urandom_range(0, sch_act_cnt - 1)];
    s = a.start + $urandom_range(0, (a.dur % DaySecs) + 1);
    if ($urandom_range(9) == 0) s = $urandom_range(0, 86399);
    return mk_item(MODE_QUERY, ($urandom_range(9) == 0) ? 3'($urandom) : a.weekday,
                   7'($urandom_range(a.y1, a.y2)), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 28)), 17'(s), 7'($urandom), 4'($urandom),
                   5'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
  endfunction

  task automatic test_refused_adds();
    write_limit(CFG_ACT_LIMIT, 5'd0);
    write_limit(CFG_EXC_LIMIT, 5'd0);
    send_item(mk_item(MODE_ADD_ACT, 3'd7, 7'd0, 4'd1, 5'd1, 17'd0,
                      7'd99, 4'd12, 5'd31, 17'd86399, 17'd0, 17'd86399));
    send_item(mk_item(MODE_ADD_EXC, 3'd0, 7'd0, 4'd1, 5'd1, 17'd0,
                      7'd99, 4'd12, 5'd31, 17'd86399, 17'd0, 17'd0));
    send_item(mk_item(MODE_QUERY, 3'd7, 7'd50, 4'd6, 5'd15, 17'd100,
                      7'd0, 4'd0, 5'd0, 17'd0, 17'd0, 17'd0));
  endtask

  task automatic test_directed();
    write_limit(CFG_ACT_LIMIT, 5'd3);
    write_limit(CFG_EXC_LIMIT, 5'd1);
    // Month zero and month fifteen clamp; day zero and day 31; seconds past a day.
    send_item(mk_item(MODE_ADD_ACT, 3'd1, 7'd0, 4'd0, 5'd0, 17'd0,
                      7'd127, 4'd15, 5'd31, 17'd131071, 17'd3600, 17'd90000));
    // Start beyond a day, compared with the seconds of the query's own date.
    send_item(mk_item(MODE_ADD_ACT, 3'd7, 7'd4, 4'd2, 5'd29, 17'd0,
                      7'd8, 4'd3, 5'd1, 17'd0, 17'd100000, 17'd3600));
    send_item(mk_item(MODE_ADD_ACT, 3'd3, 7'd10, 4'd5, 5'd1, 17'd0,
                      7'd11, 4'd5, 5'd1, 17'd0, 17'd0, 17'd86399));
    send_item(mk_item(MODE_ADD_ACT, 3'd3, 7'd10, 4'd5, 5'd1, 17'd0,
                      7'd11, 4'd5, 5'd1, 17'd0, 17'd0, 17'd86399));
    // Inside, on the edges and beyond the first activity's window.
    send_item(mk_item(MODE_QUERY, 3'd1, 7'd20, 4'd3, 5'd3, 17'd3601, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd1, 7'd20, 4'd3, 5'd3, 17'd3600, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd1, 7'd20, 4'd3, 5'd3, 17'd7199, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd1, 7'd20, 4'd3, 5'd3, 17'd7200, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd0, 7'd20, 4'd3, 5'd3, 17'd5000, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd7, 7'd5, 4'd6, 5'd10, 17'd100000, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd3, 7'd10, 4'd8, 5'd8, 17'd40000, 0, 0, 0, 0, 0, 0));
    // Unused mode leaves everything alone.
    send_item(mk_item(MODE_NOP, 3'd7, 7'd127, 4'd15, 5'd31, 17'd131071,
                      7'd127, 4'd15, 5'd31, 17'd131071, 17'd131071, 17'd131071));
    // An exception covering the query, then a second one refused by the limit.
    send_item(mk_item(MODE_ADD_EXC, 3'd2, 7'd20, 4'd3, 5'd1, 17'd0,
                      7'd20, 4'd3, 5'd5, 17'd0, 17'd0, 17'd0));
    send_item(mk_item(MODE_ADD_EXC, 3'd2, 7'd0, 4'd1, 5'd1, 17'd0,
                      7'd99, 4'd12, 5'd31, 17'd0, 17'd0, 17'd0));
    send_item(mk_item(MODE_QUERY, 3'd1, 7'd20, 4'd3, 5'd3, 17'd3601, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 3'd1, 7'd20, 4'd3, 5'd9, 17'd3601, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int unsigned n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) send_item(activity_item());
      else if (pick < 12) send_item(exception_item());
      else if (pick < 82) send_item(aimed_query());
      else send_item(noise_item());
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills.
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_calm = 1'b1;
    test_random(40);
    send_calm = 1'b0;
    drain();
  endtask

  task automatic test_streaming();
    send_calm = 1'b1;
    pop_calm = 1'b1;
    test_random(80);
    send_calm = 1'b0;
    pop_calm = 1'b0;
    drain();
  endtask

  // Receiver: random pop with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_on) pop <= 1'b0;
    else pop <= pop_calm || ($urandom_range(99) >= 36);
  end

  always begin
    @(posedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_on = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  // Result checker and stall watchdog.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      idle_cycles = 0;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (exp_v.active) hits_seen++;
        if (exp_v.active != active_o || exp_v.accepted != accepted_o ||
            exp_v.available != available_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch active/accepted/available exp %0b%0b%0b got %0b%0b%0b",
                     exp_v.active, exp_v.accepted, exp_v.available,
                     active_o, accepted_o, available_o);
        end
      end
    end else if (rst_ni && !(push && !full) && !(cfg_valid_i && cfg_ready_o)) begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    lim_act = 5'd16;
    lim_exc = 4'd8;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_refused_adds();
    test_directed();
    write_limit(CFG_ACT_LIMIT, 5'd31);
    write_limit(CFG_EXC_LIMIT, 5'd31);
    test_backpressure();
    test_streaming();
    test_random(300);
    write_limit(CFG_ACT_LIMIT, 5'd16);
    write_limit(CFG_EXC_LIMIT, 5'd8);
    test_random(180);
    drain();
    $display("Covered %0d transactions and %0d results (%0d with an open window).",
             items_sent, results_seen, hits_seen);
    $display("Tables ended with %0d activities and %0d exceptions; %0d mismatches.",
             sch_act_cnt, sch_exc_cnt, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/wswm_pkg.sv
rtl/wswm_ram.sv
rtl/wswm_fifo.sv
rtl/wswm_front.sv
rtl/wswm_back.sv
rtl/weekly_schedule_window_matcher.sv
sim/tb_top.sv
